>>> src/bgc_pkg.sv
// ----------------------------------------------------------------------------
// Bar gradient colour generator package
// Shared widths, register indexes and fixed-point constants.
// ----------------------------------------------------------------------------
package bgc_pkg;

	localparam int unsigned CHAN_W     = 16;
	localparam int unsigned COUNT_W    = 9;
	localparam int unsigned INDEX_W    = 8;
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 16;
	localparam int unsigned HUE_W      = 16;
	localparam int unsigned FRAC_W     = 17;
	localparam int unsigned DEF_MAX_BARS = 256;

	localparam logic [CFG_IDX_W-1:0] REG_BASE_RED   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BASE_GREEN = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BASE_BLUE  = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_BAR_COUNT  = 2'd3;

	localparam logic [HUE_W-1:0]  HUE_BLUE = 16'd37683;
	localparam logic [FRAC_W-1:0] ONE16    = 17'd65536;
	localparam logic [FRAC_W-1:0] V_BASE   = 17'd49152;

	// Saturation and value of one bar, unsigned fixed point with 16 fraction bits
	typedef struct packed {
		logic [FRAC_W-1:0] s;
		logic [FRAC_W-1:0] v;
	} sv_pair_t;

endpackage

>>> src/bgc_hue_unit.sv
// ----------------------------------------------------------------------------
// Base hue unit
// Works out the sextant and rotated channel bases of the configured colour.
// Division is bit-serial, one quotient bit a cycle; runs after each cfg_changed pulse.
// ----------------------------------------------------------------------------
module bgc_hue_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_changed,
	input  logic [bgc_pkg::CHAN_W-1:0]  red_q,
	input  logic [bgc_pkg::CHAN_W-1:0]  green_q,
	input  logic [bgc_pkg::CHAN_W-1:0]  blue_q,
	output logic [bgc_pkg::FRAC_W-1:0]  chan_r,
	output logic [bgc_pkg::FRAC_W-1:0]  chan_g,
	output logic [bgc_pkg::FRAC_W-1:0]  chan_b
);
	import bgc_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DIV  = 2'd1;
	localparam logic [1:0] ST_DONE = 2'd2;

	logic [1:0]          state_q;
	logic [4:0]          cnt_q;
	logic [CHAN_W-1:0]   mx, mn, d, a1, a2;
	logic [2:0]          lo;
	logic                grey;
	logic [CHAN_W:0]     num;
	logic [31:0]         dividend;
	logic [CHAN_W:0]     rem_q;
	logic [31:0]         num_q;
	logic [HUE_W-1:0]    quo_q;
	logic [CHAN_W:0]     div_q;
	logic [2:0]          lo_q;
	logic                grey_q;
	logic [CHAN_W+1:0]   shifted;
	logic [CHAN_W+1:0]   trial;
	logic                fits;
	logic [HUE_W-1:0]    hue;
	logic [HUE_W-1:0]    hue_q;
	logic [1:0]          k;
	logic [HUE_W-1:0]    rem_h;
	logic [FRAC_W-1:0]   l2, l1;

	always_comb begin
		mx = red_q;
		if (green_q > mx) mx = green_q;
		if (blue_q > mx) mx = blue_q;
		mn = red_q;
		if (green_q < mn) mn = green_q;
		if (blue_q < mn) mn = blue_q;
		d = mx - mn;
		grey = (d == '0) || ({4'd0, d} * 20'd10 < {4'd0, mx});
		if (red_q == mx) begin
			lo = 3'd0; a1 = green_q; a2 = blue_q;
		end else if (green_q == mx) begin
			lo = 3'd2; a1 = blue_q; a2 = red_q;
		end else begin
			lo = 3'd4; a1 = red_q; a2 = green_q;
		end
		num = {1'b0, a1} + {1'b0, d} - {1'b0, a2};
		// 2*num*8192 + d, divided by 2*d below
		dividend = {1'b0, num, 14'd0} + {16'd0, d};
	end

	// Restoring division, dividend bits brought down MSB first
	always_comb begin
		shifted = {rem_q, num_q[31]};
		trial   = shifted - {1'b0, div_q};
		fits    = shifted >= {1'b0, div_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			hue_q   <= HUE_BLUE;
		end else if (cfg_changed) begin
			state_q <= ST_DIV;
			cnt_q   <= 5'd31;
		end else begin
			case (state_q)
				ST_DIV: begin
					cnt_q <= cnt_q - 5'd1;
					if (cnt_q == 5'd0) state_q <= ST_DONE;
				end
				ST_DONE: begin
					hue_q   <= grey_q ? HUE_BLUE : hue;
					state_q <= ST_IDLE;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cfg_changed) begin
			rem_q  <= '0;
			num_q  <= dividend;
			quo_q  <= '0;
			div_q  <= {d, 1'b0};
			lo_q   <= lo;
			grey_q <= grey;
		end else if (state_q == ST_DIV) begin
			rem_q <= fits ? trial[CHAN_W:0] : shifted[CHAN_W:0];
			num_q <= {num_q[30:0], 1'b0};
			quo_q <= {quo_q[HUE_W-2:0], fits};
		end
	end

	always_comb begin
		hue   = {lo_q, 13'd0} + quo_q;
		k     = 2'd0;
		rem_h = hue_q;
		if (hue_q >= 16'd16384) begin k = 2'd1; rem_h = hue_q - 16'd16384; end
		if (hue_q >= 16'd32768) begin k = 2'd2; rem_h = hue_q - 16'd32768; end
		if (hue_q >= 16'd49152) begin k = 2'd0; rem_h = hue_q - 16'd49152; end
		if (rem_h < 16'd8192) begin
			l1 = '0;
			l2 = FRAC_W'({(16'd8192 - rem_h), 3'd0});
		end else begin
			l1 = FRAC_W'({(rem_h - 16'd8192), 3'd0});
			l2 = '0;
		end
		case (k)
			2'd1: begin chan_r = l2; chan_g = ONE16; chan_b = l1; end
			2'd2: begin chan_r = l1; chan_g = l2; chan_b = ONE16; end
			default: begin chan_r = ONE16; chan_g = l1; chan_b = l2; end
		endcase
	end

endmodule

>>> src/bar_gradient_color_generator_unit.sv
// ----------------------------------------------------------------------------
// Bar gradient colour generator
// Gives the RGB colour of one bar of a gradient derived from a base colour.
// ----------------------------------------------------------------------------
// One bar index is taken every cycle while start is high and busy is low;
// its colour appears with done high after stages 0 to 7, for one cycle, and
// cannot be held off by the receiver. busy is high after a write to a base
// colour register while the serial hue divider runs (32 quotient bits plus
// load and write-back); writing bar_count does not set busy. The bar
// fraction comes from a restoring divider spread over four stages, four
// quotient bits a stage, so it never limits the rate.
module bar_gradient_color_generator_unit #(
	parameter int unsigned MAX_BARS = bgc_pkg::DEF_MAX_BARS
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [bgc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [bgc_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                           start,
	output logic                           busy,
	input  logic [bgc_pkg::INDEX_W-1:0]    bar_index,
	output logic                           done,
	output logic [bgc_pkg::CHAN_W-1:0]     red_level,
	output logic [bgc_pkg::CHAN_W-1:0]     green_level,
	output logic [bgc_pkg::CHAN_W-1:0]     blue_level
);
	import bgc_pkg::*;

	// Rounded-up 2^23/10: exact floor(x/10) for x below 2^21
	localparam logic [19:0] TENTH_MUL = 20'd838861;

	logic [CHAN_W-1:0]  red_q, green_q, blue_q;
	logic [COUNT_W-1:0] count_q;
	logic               hue_go;
	logic [5:0]         hue_cnt_q;
	logic [FRAC_W-1:0]  chan_r, chan_g, chan_b;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			red_q   <= '0;
			green_q <= '0;
			blue_q  <= '0;
			count_q <= COUNT_W'(2);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_BASE_RED:   red_q   <= cfg_data;
				REG_BASE_GREEN: green_q <= cfg_data;
				REG_BASE_BLUE:  blue_q  <= cfg_data;
				REG_BAR_COUNT:  count_q <= cfg_data[COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	// Restart the hue divider in the cycle after a colour write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hue_go    <= 1'b0;
			hue_cnt_q <= '0;
		end else begin
			hue_go <= cfg_we && (cfg_index != REG_BAR_COUNT);
			if (hue_go) hue_cnt_q <= 6'd36;
			else if (hue_cnt_q != '0) hue_cnt_q <= hue_cnt_q - 6'd1;
		end
	end
	assign busy = hue_go || (hue_cnt_q != '0);

	bgc_hue_unit u_hue (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_changed(hue_go),
		.red_q      (red_q),
		.green_q    (green_q),
		.blue_q     (blue_q),
		.chan_r     (chan_r),
		.chan_g     (chan_g),
		.chan_b     (chan_b)
	);

	// Stage 0: register the accepted beat
	logic [COUNT_W-1:0] n_eff;
	logic [COUNT_W-1:0] dn;
	logic               v_s0, v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	logic [INDEX_W-1:0] bar_s0;
	logic [COUNT_W-1:0] dn_s0;

	always_comb begin
		n_eff = (32'(count_q) > MAX_BARS) ? COUNT_W'(MAX_BARS) : count_q;
		dn    = (n_eff <= COUNT_W'(1)) ? '0 : n_eff - COUNT_W'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s0 <= 1'b0; v_s1 <= 1'b0; v_s2 <= 1'b0; v_s3 <= 1'b0;
			v_s4 <= 1'b0; v_s5 <= 1'b0; v_s6 <= 1'b0; v_s7 <= 1'b0;
		end else begin
			v_s0 <= start && !busy;
			v_s1 <= v_s0; v_s2 <= v_s1; v_s3 <= v_s2;
			v_s4 <= v_s3; v_s5 <= v_s4; v_s6 <= v_s5; v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		bar_s0 <= bar_index;
		dn_s0  <= dn;
	end

	// Stages 1 to 4: bar*65536/dn, four quotient bits a stage, then round; 0 if dn is zero, 65536 if bar >= dn
	function automatic logic [COUNT_W+3:0] div4(input logic [COUNT_W-1:0] rem_in,
		input logic [COUNT_W-1:0] dv);
		logic [COUNT_W-1:0] r;
		logic [COUNT_W:0]   sh;
		logic [3:0]         q;
		r = rem_in;
		q = '0;
		for (int i = 0; i < 4; i++) begin
			sh = {r, 1'b0};
			if (sh >= {1'b0, dv}) begin
				sh = sh - {1'b0, dv};
				q  = {q[2:0], 1'b1};
			end else begin
				q  = {q[2:0], 1'b0};
			end
			r = sh[COUNT_W-1:0];
		end
		return {r, q};
	endfunction

	logic [COUNT_W+3:0] step1, step2, step3, step4;
	logic [COUNT_W-1:0] rem_s1, rem_s2, rem_s3;
	logic [COUNT_W-1:0] dn_s1, dn_s2, dn_s3;
	logic [3:0]         q_s1;
	logic [7:0]         q_s2;
	logic [11:0]        q_s3;
	logic               zero_s1, zero_s2, zero_s3;
	logic               full_s1, full_s2, full_s3;
	logic               rnd;
	logic [FRAC_W-1:0]  f_s4;

	always_comb begin
		step1 = div4(COUNT_W'(bar_s0), dn_s0);
		step2 = div4(rem_s1, dn_s1);
		step3 = div4(rem_s2, dn_s2);
		step4 = div4(rem_s3, dn_s3);
		// Round half up: remainder at least half the divisor
		rnd   = {step4[COUNT_W+3:4], 1'b0} >= {1'b0, dn_s3};
	end

	always_ff @(posedge clk) begin
		rem_s1  <= step1[COUNT_W+3:4];
		q_s1    <= step1[3:0];
		dn_s1   <= dn_s0;
		zero_s1 <= (dn_s0 == '0);
		full_s1 <= (COUNT_W'(bar_s0) >= dn_s0);
		rem_s2  <= step2[COUNT_W+3:4];
		q_s2    <= {q_s1, step2[3:0]};
		dn_s2   <= dn_s1;
		zero_s2 <= zero_s1;
		full_s2 <= full_s1;
		rem_s3  <= step3[COUNT_W+3:4];
		q_s3    <= {q_s2, step3[3:0]};
		dn_s3   <= dn_s2;
		zero_s3 <= zero_s2;
		full_s3 <= full_s2;
		if (zero_s3) f_s4 <= '0;
		else if (full_s3) f_s4 <= ONE16;
		else f_s4 <= FRAC_W'({q_s3, step4[3:0]}) + FRAC_W'(rnd);
	end

	// Stage 5: saturation and value
	sv_pair_t    sv_s5;
	logic [19:0] nine_f;
	logic [39:0] tenth_p;

	always_comb begin
		nine_f  = 20'(f_s4) * 20'd9 + 20'd5;
		tenth_p = {20'd0, nine_f} * {20'd0, TENTH_MUL};
	end

	always_ff @(posedge clk) begin
		sv_s5.s <= ONE16 - FRAC_W'(tenth_p >> 23);
		sv_s5.v <= V_BASE + FRAC_W'((18'(f_s4) + 18'd2) >> 2);
	end

	// Stage 6: inner = 1 - round(s*(1-c)), stage 7: out = round(v*inner)
	logic [FRAC_W-1:0] in_r_s6, in_g_s6, in_b_s6, value_s6;
	function automatic logic [FRAC_W-1:0] inner_f(input logic [FRAC_W-1:0] s,
		input logic [FRAC_W-1:0] c);
		logic [33:0] p;
		p = 34'(s) * 34'(ONE16 - c) + 34'd32768;
		return ONE16 - FRAC_W'(p >> 16);
	endfunction
	function automatic logic [CHAN_W-1:0] out_f(input logic [FRAC_W-1:0] v,
		input logic [FRAC_W-1:0] x);
		logic [33:0] p;
		p = 34'(v) * 34'(x) + 34'd32768;
		return (p[33:16] > 18'd65535) ? 16'hFFFF : p[31:16];
	endfunction

	always_ff @(posedge clk) begin
		in_r_s6     <= inner_f(sv_s5.s, chan_r);
		in_g_s6     <= inner_f(sv_s5.s, chan_g);
		in_b_s6     <= inner_f(sv_s5.s, chan_b);
		value_s6    <= sv_s5.v;
		red_level   <= out_f(value_s6, in_r_s6);
		green_level <= out_f(value_s6, in_g_s6);
		blue_level  <= out_f(value_s6, in_b_s6);
	end

	assign done = v_s7;

`ifndef NO_ASSERTIONS
	a_done_follows: assert property (@(posedge clk) disable iff (!arst_n)
		v_s0 |-> ##7 done) else $error("result beat lost");
	a_no_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		hue_go |-> busy) else $error("busy low during hue update");
`endif

endmodule
